// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion wrappers that a build can compile out
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property checked on every clock edge outside reset
`define SMG_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
// implication checked on every clock edge outside reset
`define SMG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define SMG_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define SMG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/smg_pkg.sv
// ----------------------------------------------------------------------------
// smg_pkg
// shared types and codes of the stable merge sorter
// ----------------------------------------------------------------------------
package smg_pkg;

    localparam int KEY_W = 32;
    localparam int TAG_W = 16;
    localparam int REC_W = KEY_W + TAG_W;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_FETCH = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [KEY_W-1:0] sort_key;
        logic [TAG_W-1:0] record_tag;
        logic             is_last;
    } t_in;

    typedef struct packed {
        logic [KEY_W-1:0] out_key;
        logic [TAG_W-1:0] out_tag;
        logic             out_last;
        logic             overflowed;
    } t_out;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_rec;

    typedef struct packed {
        logic busy;
        logic src_b;
        logic wr_en;
    } t_merge_stat;

endpackage

// File: src/smg_ram.sv
// ----------------------------------------------------------------------------
// smg_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module smg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr0,
    input  logic [$clog2(DEPTH)-1:0] i_raddr1,
    output logic [WIDTH-1:0]         o_rdata0,
    output logic [WIDTH-1:0]         o_rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata0;
    logic [WIDTH-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata0 <= mem[i_raddr0];
        r_rdata1 <= mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

// File: src/smg_merge.sv
// ----------------------------------------------------------------------------
// smg_merge
// bottom-up merge sequencer between two rams, one element merged per cycle except while a pair of runs is opened
// ----------------------------------------------------------------------------
module smg_merge #(
    parameter int MAX_RECORDS = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [$clog2(MAX_RECORDS+1)-1:0]   i_count,
    input  smg_pkg::t_rec                      i_rd0,
    input  smg_pkg::t_rec                      i_rd1,
    output smg_pkg::t_merge_stat               o_stat,
    output logic [$clog2(MAX_RECORDS)-1:0]     o_wr_addr,
    output smg_pkg::t_rec                      o_wr_data,
    output logic [$clog2(MAX_RECORDS)-1:0]     o_raddr0,
    output logic [$clog2(MAX_RECORDS)-1:0]     o_raddr1
);

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int XW = CW + 2;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_PRIME = 2'd1;
    localparam logic [1:0] S_FILL  = 2'd2;
    localparam logic [1:0] S_MERGE = 2'd3;

    logic [1:0]    r_state, n_state;
    logic          r_src_b, n_src_b;
    logic [CW-1:0] r_n, n_n;
    logic [XW-1:0] r_w, n_w;
    logic [XW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;
    smg_pkg::t_rec r_hl, n_hl;
    smg_pkg::t_rec r_hr, n_hr;

    logic [CW-1:0] lo_c;
    logic [CW-1:0] w_c;
    logic [CW-1:0] rem_lo;
    logic [CW-1:0] mid_c;
    logic [CW-1:0] rem_mid;
    logic [CW-1:0] hi_c;
    logic          take_l;
    logic [CW-1:0] k_inc;
    logic [XW-1:0] lo_nx;
    logic [XW-1:0] w_nx;
    logic [CW-1:0] i_nx;
    logic [CW-1:0] j_nx;
    logic [CW-1:0] i_fwd;
    logic [CW-1:0] j_fwd;

    // run bounds of the pair starting at lo
    assign lo_c    = r_lo[CW-1:0];
    assign w_c     = r_w[CW-1:0];
    assign rem_lo  = r_n - lo_c;
    assign mid_c   = (XW'(rem_lo) > r_w) ? lo_c + w_c : r_n;
    assign rem_mid = r_n - mid_c;
    assign hi_c    = (XW'(rem_mid) > r_w) ? mid_c + w_c : r_n;

    // a tie takes the left run, which keeps the sort stable
    assign take_l = (r_i < r_mid) && ((r_j >= r_hi) || (r_hl.key <= r_hr.key));
    assign k_inc  = r_k + CW'(1);
    assign lo_nx  = r_lo + (r_w << 1);
    assign w_nx   = r_w << 1;
    assign i_nx   = take_l ? r_i + CW'(1) : r_i;
    assign j_nx   = take_l ? r_j : r_j + CW'(1);
    assign i_fwd  = i_nx + CW'(1);
    assign j_fwd  = j_nx + CW'(1);

    always_comb begin
        n_state = r_state;
        n_src_b = r_src_b;
        n_n     = r_n;
        n_w     = r_w;
        n_lo    = r_lo;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_hl    = r_hl;
        n_hr    = r_hr;
        o_raddr0 = '0;
        o_raddr1 = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_n     = i_count;
                    n_w     = XW'(1);
                    n_lo    = '0;
                    n_src_b = 1'b0;
                    if (i_count > CW'(1)) begin
                        n_state = S_PRIME;
                    end
                end
            end
            S_PRIME: begin
                n_mid    = mid_c;
                n_hi     = hi_c;
                n_i      = lo_c;
                n_j      = mid_c;
                n_k      = lo_c;
                o_raddr0 = lo_c[AW-1:0];
                o_raddr1 = mid_c[AW-1:0];
                n_state  = S_FILL;
            end
            S_FILL: begin
                // heads arrive, prefetch the elements behind them
                n_hl     = i_rd0;
                n_hr     = i_rd1;
                o_raddr0 = AW'(r_i + CW'(1));
                o_raddr1 = AW'(r_j + CW'(1));
                n_state  = S_MERGE;
            end
            S_MERGE: begin
                n_i = i_nx;
                n_j = j_nx;
                n_k = k_inc;
                if (take_l) begin
                    n_hl = i_rd0;
                end else begin
                    n_hr = i_rd1;
                end
                o_raddr0 = i_fwd[AW-1:0];
                o_raddr1 = j_fwd[AW-1:0];
                if (k_inc == r_hi) begin
                    if (lo_nx >= XW'(r_n)) begin
                        n_lo    = '0;
                        n_w     = w_nx;
                        n_src_b = !r_src_b;
                        n_state = (w_nx >= XW'(r_n)) ? S_IDLE : S_PRIME;
                    end else begin
                        n_lo    = lo_nx;
                        n_state = S_PRIME;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_src_b <= 1'b0;
        end else begin
            r_state <= n_state;
            r_src_b <= n_src_b;
        end
        r_n   <= n_n;
        r_w   <= n_w;
        r_lo  <= n_lo;
        r_mid <= n_mid;
        r_hi  <= n_hi;
        r_i   <= n_i;
        r_j   <= n_j;
        r_k   <= n_k;
        r_hl  <= n_hl;
        r_hr  <= n_hr;
    end

    assign o_stat.busy  = (r_state != S_IDLE);
    assign o_stat.src_b = r_src_b;
    assign o_stat.wr_en = (r_state == S_MERGE);
    assign o_wr_addr    = r_k[AW-1:0];
    assign o_wr_data    = take_l ? r_hl : r_hr;

endmodule

// File: src/stable_merge_sorter.sv
// ----------------------------------------------------------------------------
// stable_merge_sorter
// stable ascending sort of keyed records over two ping-pong memories
// ----------------------------------------------------------------------------
// A load item writes its record into memory A while there is room; a load
// with is_last sorts the batch bottom-up, raising busy when it holds more
// than one record, and merges runs of width 1, 2, 4 and so on between
// memories A and B. The merge moves one record per cycle through the two
// read ports of the source memory, pausing in its prime and fill states to
// open each pair of runs. A fetch item's result strobes on o_valid in the
// next cycle; fetches may follow back to back. No memory clearing pass runs
// after reset.
`include "assert_macros.svh"

module stable_merge_sorter #(
    parameter int MAX_RECORDS = 1024
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  smg_pkg::t_in   i_item,
    output logic           busy,
    output logic           o_valid,
    output smg_pkg::t_out  o_result
);

    localparam int AW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rd_pos, n_rd_pos;
    logic          r_sorted, n_sorted;
    logic          r_ovf, n_ovf;
    logic          r_valid, n_valid;
    logic          r_out_last, n_out_last;
    logic          r_out_ovf, n_out_ovf;

    logic          accept;
    logic          load;
    logic          fetch_ok;
    logic [CW-1:0] cnt_eff;
    logic          room;
    logic          load_we;
    logic          sort_start;

    smg_pkg::t_merge_stat m_stat;
    logic [AW-1:0]        m_wr_addr;
    smg_pkg::t_rec        m_wr_data;
    logic [AW-1:0]        m_raddr0;
    logic [AW-1:0]        m_raddr1;

    logic                 a_we;
    logic [AW-1:0]        a_waddr;
    logic [smg_pkg::REC_W-1:0] a_wdata;
    logic [AW-1:0]        raddr0;
    logic [smg_pkg::REC_W-1:0] a_rd0, a_rd1, b_rd0, b_rd1;
    smg_pkg::t_rec        src_rd0;
    smg_pkg::t_rec        src_rd1;
    smg_pkg::t_rec        load_rec;

    assign accept   = start && !m_stat.busy;
    assign load     = accept && (i_item.mode == smg_pkg::MODE_LOAD);
    assign fetch_ok = accept && (i_item.mode == smg_pkg::MODE_FETCH) && r_sorted
                      && (r_rd_pos < r_count);

    // a load after a finished sort starts a new batch
    assign cnt_eff    = r_sorted ? '0 : r_count;
    assign room       = cnt_eff < CW'(MAX_RECORDS);
    assign load_we    = load && room;
    assign sort_start = load && i_item.is_last;

    always_comb begin
        n_count    = r_count;
        n_rd_pos   = r_rd_pos;
        n_sorted   = r_sorted;
        n_ovf      = r_ovf;
        n_valid    = fetch_ok;
        n_out_last = r_out_last;
        n_out_ovf  = r_out_ovf;
        if (load) begin
            n_count  = room ? cnt_eff + CW'(1) : cnt_eff;
            n_ovf    = (r_ovf && !r_sorted) || !room;
            n_rd_pos = r_sorted ? '0 : r_rd_pos;
            n_sorted = 1'b0;
            if (i_item.is_last) begin
                n_rd_pos = '0;
                n_sorted = 1'b1;
            end
        end else if (fetch_ok) begin
            n_rd_pos   = r_rd_pos + CW'(1);
            n_out_last = (r_rd_pos + CW'(1)) == r_count;
            n_out_ovf  = r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_pos <= '0;
            r_sorted <= 1'b0;
            r_ovf    <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_rd_pos <= n_rd_pos;
            r_sorted <= n_sorted;
            r_ovf    <= n_ovf;
            r_valid  <= n_valid;
        end
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign load_rec.key = i_item.sort_key;
    assign load_rec.tag = i_item.record_tag;

    // memory A takes loads while idle and merge output on the passes that read memory B
    assign a_we    = load_we || (m_stat.wr_en && m_stat.src_b);
    assign a_waddr = load_we ? cnt_eff[AW-1:0] : m_wr_addr;
    assign a_wdata = load_we ? load_rec : m_wr_data;
    assign raddr0  = m_stat.busy ? m_raddr0 : r_rd_pos[AW-1:0];

    smg_ram #(
        .WIDTH (smg_pkg::REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_store_a (
        .i_clk    (i_clk),
        .i_we     (a_we),
        .i_waddr  (a_waddr),
        .i_wdata  (a_wdata),
        .i_raddr0 (raddr0),
        .i_raddr1 (m_raddr1),
        .o_rdata0 (a_rd0),
        .o_rdata1 (a_rd1)
    );

    smg_ram #(
        .WIDTH (smg_pkg::REC_W),
        .DEPTH (MAX_RECORDS)
    ) u_store_b (
        .i_clk    (i_clk),
        .i_we     (m_stat.wr_en && !m_stat.src_b),
        .i_waddr  (m_wr_addr),
        .i_wdata  (m_wr_data),
        .i_raddr0 (raddr0),
        .i_raddr1 (m_raddr1),
        .o_rdata0 (b_rd0),
        .o_rdata1 (b_rd1)
    );

    assign src_rd0 = smg_pkg::t_rec'(m_stat.src_b ? b_rd0 : a_rd0);
    assign src_rd1 = smg_pkg::t_rec'(m_stat.src_b ? b_rd1 : a_rd1);

    smg_merge #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sort_start),
        .i_count   (n_count),
        .i_rd0     (src_rd0),
        .i_rd1     (src_rd1),
        .o_stat    (m_stat),
        .o_wr_addr (m_wr_addr),
        .o_wr_data (m_wr_data),
        .o_raddr0  (m_raddr0),
        .o_raddr1  (m_raddr1)
    );

    assign busy                = m_stat.busy;
    assign o_valid             = r_valid;
    assign o_result.out_key    = src_rd0.key;
    assign o_result.out_tag    = src_rd0.tag;
    assign o_result.out_last   = r_out_last;
    assign o_result.overflowed = r_out_ovf;

    `SMG_ASSERT_IMP(a_valid_after_fetch, i_clk, i_rst_n, r_valid, $past(fetch_ok), "result strobe without an accepted fetch")
    `SMG_ASSERT_RST(a_count_in_range, i_clk, i_rst_n, r_count <= CW'(MAX_RECORDS), "record count beyond capacity")
    `SMG_ASSERT_IMP(a_sort_state, i_clk, i_rst_n, m_stat.busy, r_sorted && (r_rd_pos == '0), "sort running outside a fresh sorted batch")
    `SMG_ASSERT_IMP(a_merge_wr_in_batch, i_clk, i_rst_n, m_stat.wr_en, CW'(m_wr_addr) < r_count, "merge write beyond the batch")

endmodule
